>>> rtl/saf_pkg.sv
package saf_pkg;

  localparam int LOC_W = 32;
  localparam int WINDOW_DEPTH_DEF = 4;
  localparam logic [LOC_W-1:0] DISTANCE_LIMIT_RESET = LOC_W'(1000);

  typedef struct packed {
    logic             full;
    logic [LOC_W-1:0] oldest;
  } win_status_t;

endpackage

>>> rtl/strand_adjacency_filter_core.sv
// A hit is registered in the main or skid buffer entry; out_valid shows the main one.
// One location per cycle while in_stall is low; the window compare is combinational.
// in_stall rises only while both entries of the two-entry result buffer hold hits.
// Reset (rst, synchronous, active high): both fill counters clear, the result buffer
// empties and distance_limit returns to 1000; window contents are not cleared.
module strand_adjacency_filter_core import saf_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LOC_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LOC_W-1:0] location,
  input  logic             last_of_read,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LOC_W-1:0] hit_location
);

  logic [LOC_W-1:0] distance_limit;
  logic             in_accept;
  logic             strand_one;
  win_status_t      status_one;
  win_status_t      status_zero;
  win_status_t      status_sel;
  logic [LOC_W-1:0] span;
  logic             hit;
  logic             buf_full;

  // hold the adjacency limit; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= DISTANCE_LIMIT_RESET;
    end else if (cfg_we) begin
      distance_limit <= cfg_wdata;
    end
  end

  // stall only when the skid entry is taken, so a request can still land
  // while a finished hit waits downstream
  assign in_stall   = buf_full;
  assign in_accept  = in_valid && !in_stall;
  assign strand_one = location[0];

  saf_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_win_one (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (in_accept && strand_one),
    .clear_fill(in_accept && last_of_read),
    .shift_loc (location),
    .status    (status_one)
  );

  saf_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_win_zero (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (in_accept && !strand_one),
    .clear_fill(in_accept && last_of_read),
    .shift_loc (location),
    .status    (status_zero)
  );

  // compare against the oldest entry of this strand's window; the span wraps
  assign status_sel = strand_one ? status_one : status_zero;
  assign span       = location - status_sel.oldest;
  assign hit        = in_accept && status_sel.full && (span < distance_limit);

  // drop the strand flag from the emitted location
  saf_out_buffer u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (hit),
    .push_data({status_sel.oldest[LOC_W-1:1], 1'b0}),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (hit_location)
  );

endmodule

>>> rtl/saf_window.sv
module saf_window import saf_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             clear_fill,
  input  logic [LOC_W-1:0] shift_loc,
  output win_status_t      status
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);

  logic [LOC_W-1:0]  win [WINDOW_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    fill_next = fill;
    if (shift_en && (fill != FILL_MAX)) begin
      fill_next = fill + FILL_W'(1);
    end
    if (clear_fill) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // shift toward entry 0; entry 0 is the oldest
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WINDOW_DEPTH-1] <= shift_loc;
    end
  end

  assign status.full   = (fill == FILL_MAX);
  assign status.oldest = win[0];

endmodule

>>> rtl/saf_out_buffer.sv
module saf_out_buffer import saf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [LOC_W-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LOC_W-1:0] out_data
);

  logic             main_valid;
  logic [LOC_W-1:0] main_data;
  logic             skid_valid;
  logic [LOC_W-1:0] skid_data;
  logic             take;

  assign take      = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // push never arrives while the skid entry is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule
